@@ hdl/fps_pkg.sv @@
// ----------------------------------------------------------------------------
// fps_pkg
// Shared constants, codes and control structs of the frame packet segmenter.
// ----------------------------------------------------------------------------
package fps_pkg;

  // payload and frame sizing
  localparam int PAYLOAD_BYTES   = 248;
  localparam int FRAME_BYTES_MAX = 131072;
  localparam int PAY_WORDS       = (PAYLOAD_BYTES + 7) / 8;
  localparam int FILL_W          = $clog2(PAYLOAD_BYTES);
  localparam int WADDR_W         = (PAY_WORDS > 1) ? $clog2(PAY_WORDS) : 1;
  localparam int CNT_W           = $clog2(FRAME_BYTES_MAX + 1);

  // format codes on the input
  localparam logic [1:0] FMT_MJPEG = 2'd1;
  localparam logic [1:0] FMT_RAW   = 2'd2;

  // type codes in the header
  localparam logic [2:0] TYPE_NONE  = 3'd0;
  localparam logic [2:0] TYPE_MJPEG = 3'd2;
  localparam logic [2:0] TYPE_RAW   = 3'd4;

  // frame id wrap point
  localparam logic [7:0] ID_MAX   = 8'd255;
  localparam logic [7:0] ID_FIRST = 8'd1;

  // controller to datapath
  typedef struct packed {
    logic               accept;
    logic               load_hdr;
    logic               rd_en;
    logic [WADDR_W-1:0] rd_addr;
    logic               load_word;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pkt_full;
  } status_t;

endpackage

@@ hdl/fps_dpath.sv @@
// ----------------------------------------------------------------------------
// fps_dpath
// Byte assembly, payload word memory, frame counters and output word register.
// ----------------------------------------------------------------------------
module fps_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_frame_start,
  input  logic                 in_frame_end,
  input  logic [1:0]           in_format_code,
  input  fps_pkg::cmd_t        cmd,
  output fps_pkg::status_t     st,
  output logic [63:0]          out_word
);

  logic [fps_pkg::FILL_W-1:0]  fill_r, fill_nxt, fill_eff;
  logic [fps_pkg::CNT_W-1:0]   cnt_r, cnt_nxt, cnt_eff;
  logic [7:0]                  id_r, id_nxt;
  logic [2:0]                  type_r, type_nxt;
  logic                        active_r, active_nxt, active_eff;
  logic [63:0]                 asm_r, asm_nxt;
  logic [63:0]                 rd_data_r;
  logic [63:0]                 out_word_r;
  logic [63:0]                 hdr;
  logic [31:0]                 offset;
  logic [2:0]                  lane;
  logic [fps_pkg::WADDR_W-1:0] waddr;
  logic                        take, full, wr_en;

  logic [63:0] mem [fps_pkg::PAY_WORDS];

  // byte acceptance and next state of the frame counters
  always_comb begin
    active_eff = in_frame_start | active_r;
    cnt_eff    = in_frame_start ? '0 : cnt_r;
    fill_eff   = in_frame_start ? '0 : fill_r;
    take       = active_eff && (cnt_eff < fps_pkg::CNT_W'(fps_pkg::FRAME_BYTES_MAX));
    full       = take && (fill_eff == fps_pkg::FILL_W'(fps_pkg::PAYLOAD_BYTES - 1));
    lane       = fill_eff[2:0];
    waddr      = fps_pkg::WADDR_W'(fill_eff >> 3);

    id_nxt   = id_r;
    type_nxt = type_r;
    if (in_frame_start) begin
      id_nxt = (id_r == fps_pkg::ID_MAX) ? fps_pkg::ID_FIRST : id_r + 8'd1;
      case (in_format_code)
        fps_pkg::FMT_MJPEG: type_nxt = fps_pkg::TYPE_MJPEG;
        fps_pkg::FMT_RAW:   type_nxt = fps_pkg::TYPE_RAW;
        default:            type_nxt = fps_pkg::TYPE_NONE;
      endcase
    end

    // new word starts from zero so a short last word has zero high bytes
    asm_nxt = (lane == 3'd0) ? 64'd0 : asm_r;
    asm_nxt[lane*8 +: 8] = in_data_byte;
    wr_en = cmd.accept && take && ((lane == 3'd7) || full);

    cnt_nxt  = take ? cnt_eff + 1'b1 : cnt_eff;
    fill_nxt = fill_eff;
    if (take) begin
      fill_nxt = full ? '0 : fill_eff + 1'b1;
    end
    active_nxt = active_eff;
    if (in_frame_end) begin
      active_nxt = 1'b0;
      fill_nxt   = '0;
    end
  end

  assign st.pkt_full = full;

  // header word of the packet being started
  always_comb begin
    offset = 32'(cnt_nxt) - 32'(fps_pkg::PAYLOAD_BYTES);
    hdr    = {offset, 5'd0, type_nxt, id_nxt, 16'(fps_pkg::PAYLOAD_BYTES)};
  end

  // frame control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      cnt_r    <= '0;
      id_r     <= '0;
      type_r   <= fps_pkg::TYPE_NONE;
      active_r <= 1'b0;
    end else if (cmd.accept) begin
      fill_r   <= fill_nxt;
      cnt_r    <= cnt_nxt;
      id_r     <= id_nxt;
      type_r   <= type_nxt;
      active_r <= active_nxt;
    end
  end

  // word assembly register
  always_ff @(posedge clk) begin
    if (cmd.accept && take) begin
      asm_r <= asm_nxt;
    end
  end

  // payload word memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= asm_nxt;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[cmd.rd_addr];
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      out_word_r <= hdr;
    end else if (cmd.load_word) begin
      out_word_r <= rd_data_r;
    end
  end

  assign out_word = out_word_r;

endmodule

@@ hdl/fps_ctrl.sv @@
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer: takes bytes while filling, then sends one packet word by word.
// ----------------------------------------------------------------------------
module fps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_last_word,
  output fps_pkg::cmd_t     cmd,
  input  fps_pkg::status_t  st
);

  typedef enum logic [1:0] {
    S_FILL,
    S_SEND,
    S_READ
  } state_t;

  state_t                      state_r, state_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [fps_pkg::WADDR_W-1:0] word_idx_r, word_idx_nxt;
  logic                        out_take;

  assign out_take = out_valid_r && !out_stall;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_last_nxt  = out_last_r;
    word_idx_nxt  = word_idx_r;
    cmd           = '0;
    cmd.rd_addr   = word_idx_r;
    unique case (state_r)
      S_FILL: begin
        cmd.accept   = in_valid;
        cmd.load_hdr = in_valid && st.pkt_full;
        if (in_valid && st.pkt_full) begin
          state_nxt     = S_SEND;
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          word_idx_nxt  = '0;
        end
      end
      S_SEND: begin
        if (out_take) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            state_nxt = S_FILL;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.load_word = 1'b1;
        out_valid_nxt = 1'b1;
        out_last_nxt  = (word_idx_r == fps_pkg::WADDR_W'(fps_pkg::PAY_WORDS - 1));
        word_idx_nxt  = word_idx_r + 1'b1;
        state_nxt     = S_SEND;
      end
      default: state_nxt = S_FILL;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_FILL;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      word_idx_r  <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      out_last_r  <= out_last_nxt;
      word_idx_r  <= word_idx_nxt;
    end
  end

  assign in_stall      = (state_r != S_FILL);
  assign out_valid     = out_valid_r;
  assign out_last_word = out_last_r;

`ifndef NO_ASSERTIONS
  // a completed payload presents its header on the next cycle
  a_hdr_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && st.pkt_full |=> out_valid && !out_last_word)
    else $error("header word not presented after full payload");

  // no byte is taken while a packet is being sent
  a_send_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while packet word pending");

  // after the last word the block returns to filling
  a_last_ends_packet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last_word |=> !out_valid && !in_stall)
    else $error("packet did not end after last word");
`endif

endmodule

@@ hdl/frame_packet_segmenter.sv @@
// Header: the header word is valid in the cycle after the byte that fills a payload.
// Each payload word is read from memory once the previous word is taken, then sent.
// Throughput: one byte per cycle while filling; input is stalled during a packet,
// so no byte is taken until the last word of the packet has been taken.
// Reset: synchronous, active low; clears counters, frame id, type and sequencer state.
// The payload memory is not cleared; every word is rewritten before it is sent.
// ----------------------------------------------------------------------------
// frame_packet_segmenter
// Cuts video frame bytes into fixed payloads and sends each as a packet of
// a header word and little-endian 64-bit payload words.
// ----------------------------------------------------------------------------
module frame_packet_segmenter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_start,
  input  logic        in_frame_end,
  input  logic [1:0]  in_format_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_word,
  output logic        out_last_word
);

  fps_pkg::cmd_t    cmd;
  fps_pkg::status_t st;

  // sequencer
  fps_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_last_word (out_last_word),
    .cmd           (cmd),
    .st            (st)
  );

  // payload datapath
  fps_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .in_format_code (in_format_code),
    .cmd            (cmd),
    .st             (st),
    .out_word       (out_word)
  );

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// frame packet segmenter testbench
// Sends frame bytes through the request channel and keeps a byte-level model
// of the segmenter that builds the packet words each byte should produce.
// Every word leaving the block is compared, in order, with those packet
// words. A table of hand-picked requests covers bytes with no frame open, a
// one-byte frame, a frame abandoned by a new start and a full payload that
// ends its frame, sent while the output is held off for a long stretch.
// Short random frames follow in several idle and stall phases.
// ----------------------------------------------------------------------------
module testbench;

  // format codes the package does not name
  localparam logic [1:0] FMT_UNKNOWN = 2'd0;
  localparam logic [1:0] FMT_UNUSED  = 2'd3;

  localparam int CYCLE_LIMIT = 50000;
  localparam int HOLD_CYCLES = 600;
  localparam int TAIL_CYCLES = 100;
  localparam int CALM_CYCLES = 40;
  localparam int NUM_ROWS    = 5;
  localparam int HOLD_ROW    = 3;
  localparam int NUM_PHASES  = 4;
  localparam int PHASE_BYTES = 16;

  typedef enum logic [1:0] {DATA_INCR, DATA_CONST, DATA_RAND} fill_mode_t;

  // one run of bytes: flags, format, data pattern and an optional header
  typedef struct packed {
    int         count;
    bit         start_first;
    bit         start_each;
    bit         end_last;
    bit         end_each;
    logic [1:0] fmt;
    fill_mode_t mode;
    logic [7:0] base;
    bit         typed;
    logic [63:0] hdr;
  } byte_run_t;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } packet_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_data_byte;
  logic        in_frame_start;
  logic        in_frame_end;
  logic [1:0]  in_format_code;
  logic        out_valid;
  logic        out_stall;
  logic [63:0] out_word;
  logic        out_last_word;

  // segmenter model state
  logic [7:0] seg_store [fps_pkg::PAYLOAD_BYTES];
  int         seg_fill;
  int         seg_bytes;
  logic [7:0] seg_id;
  logic [2:0] seg_type;
  bit         seg_active;

  packet_word_t packet_words_due [$];

  int bad_count;
  int bytes_taken;
  int cycle_count;
  int tx_idle_pct;
  int rx_stall_pct;
  int calm_tx;
  int calm_rx;
  bit hold_req;
  bit hold_on;

  // hand-picked runs, headers typed in where they are obvious
  byte_run_t table_runs [NUM_ROWS] = '{
    // bytes with no frame open are dropped
    '{3, 1'b0, 1'b0, 1'b0, 1'b0, fps_pkg::FMT_MJPEG, DATA_CONST, 8'hFF, 1'b0, 64'h0},
    // start and end on the same byte
    '{1, 1'b1, 1'b0, 1'b1, 1'b0, fps_pkg::FMT_RAW, DATA_RAND, 8'h00, 1'b0, 64'h0},
    // frame left open, then abandoned by a new start
    '{12, 1'b1, 1'b0, 1'b0, 1'b0, FMT_UNUSED, DATA_RAND, 8'h00, 1'b0, 64'h0},
    // end on the byte that fills the payload
    '{fps_pkg::PAYLOAD_BYTES, 1'b1, 1'b0, 1'b1, 1'b0, fps_pkg::FMT_MJPEG, DATA_INCR,
      8'h00, 1'b1, 64'h0000_0000_0203_00F8},
    // bytes after the frame end are dropped
    '{2, 1'b0, 1'b0, 1'b0, 1'b0, fps_pkg::FMT_RAW, DATA_RAND, 8'h00, 1'b0, 64'h0}
  };

  frame_packet_segmenter dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_data_byte   (in_data_byte),
    .in_frame_start (in_frame_start),
    .in_frame_end   (in_frame_end),
    .in_format_code (in_format_code),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_word       (out_word),
    .out_last_word  (out_last_word)
  );

  // clock
  always begin
    #1 clk = 1'b0;
    #1 clk = 1'b1;
  end

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("mismatch %s: got %h want %h at cycle %0d", what, got, want,
             cycle_count);
    bad_count++;
  endtask

  // model one accepted byte, queue the packet words it completes
  task automatic segment_byte(input logic [7:0] b, input logic s, input logic e,
                              input logic [1:0] f, output bit used,
                              output bit made);
    logic [63:0]  word;
    packet_word_t pw;
    int           idx;
    used = 1'b0;
    made = 1'b0;
    if (s) begin
      seg_id     = (seg_id == fps_pkg::ID_MAX) ? fps_pkg::ID_FIRST : seg_id + 8'd1;
      seg_type   = (f == fps_pkg::FMT_MJPEG) ? fps_pkg::TYPE_MJPEG :
                   ((f == fps_pkg::FMT_RAW) ? fps_pkg::TYPE_RAW : fps_pkg::TYPE_NONE);
      seg_bytes  = 0;
      seg_fill   = 0;
      seg_active = 1'b1;
    end
    if (seg_active && seg_bytes < fps_pkg::FRAME_BYTES_MAX) begin
      used = 1'b1;
      seg_store[seg_fill] = b;
      seg_fill++;
      seg_bytes++;
      if (seg_fill == fps_pkg::PAYLOAD_BYTES) begin
        pw.word = {32'(seg_bytes - fps_pkg::PAYLOAD_BYTES), 5'd0, seg_type, seg_id,
                   16'(fps_pkg::PAYLOAD_BYTES)};
        pw.last = 1'b0;
        packet_words_due.push_back(pw);
        for (int w = 0; w < fps_pkg::PAY_WORDS; w++) begin
          word = '0;
          for (int k = 0; k < 8; k++) begin
            idx = w * 8 + k;
            if (idx < fps_pkg::PAYLOAD_BYTES) word[8*k +: 8] = seg_store[idx];
          end
          pw.word = word;
          pw.last = (w == fps_pkg::PAY_WORDS - 1);
          packet_words_due.push_back(pw);
        end
        seg_fill = 0;
        made = 1'b1;
      end
    end
    if (e) begin
      seg_active = 1'b0;
      seg_fill   = 0;
    end
  endtask

  // offer one request, wait for it to be taken, then model it
  task automatic send_byte(input logic [7:0] b, input logic s, input logic e,
                           input logic [1:0] f, output bit made);
    bit gap;
    bit stalled;
    bit used;
    gap = 1'b1;
    while (gap) begin
      if (calm_tx > 0) begin
        calm_tx--;
        gap = 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_tx = CALM_CYCLES;
        gap = 1'b0;
      end else begin
        gap = ($urandom_range(0, 99) < tx_idle_pct);
      end
      if (gap) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_data_byte   <= b;
    in_frame_start <= s;
    in_frame_end   <= e;
    in_format_code <= f;
    do begin
      @(negedge clk);
      stalled = in_stall;
      @(posedge clk);
    end while (stalled);
    segment_byte(b, s, e, f, used, made);
    if (used) bytes_taken++;
  endtask

  // send a run of bytes; a typed header replaces the first modeled one
  task automatic send_run(input byte_run_t run);
    bit         hdr_due;
    bit         made;
    logic       s;
    logic       e;
    logic [7:0] b;
    int         idx;
    hdr_due = run.typed;
    for (int i = 0; i < run.count; i++) begin
      s = run.start_each || (run.start_first && i == 0);
      e = run.end_each || (run.end_last && i == run.count - 1);
      case (run.mode)
        DATA_INCR:  b = run.base + 8'(i);
        DATA_CONST: b = run.base;
        default:    b = 8'($urandom);
      endcase
      send_byte(b, s, e, run.fmt, made);
      if (made && hdr_due) begin
        idx = packet_words_due.size() - fps_pkg::PAY_WORDS - 1;
        if (packet_words_due[idx].word !== run.hdr)
          flag_mismatch("modeled header vs table", packet_words_due[idx].word, run.hdr);
        packet_words_due[idx].word = run.hdr;
        hdr_due = 1'b0;
      end
    end
  endtask

  // wait at least one edge, then until every due word is out
  task automatic drain_words();
    do @(posedge clk); while (packet_words_due.size() != 0);
  endtask

  // long output hold-off, counted in cycles
  initial begin
    hold_on = 1'b0;
    wait (hold_req);
    @(negedge clk);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_on = 1'b0;
  end

  // output side: check taken words, then pick the next stall
  initial begin
    bit           seen;
    logic [63:0]  got_word;
    logic         got_last;
    bit           nxt;
    packet_word_t want;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      seen     = rst_n && out_valid && !out_stall;
      got_word = out_word;
      got_last = out_last_word;
      @(posedge clk);
      if (seen) begin
        if (packet_words_due.size() == 0) begin
          flag_mismatch("word with none due", got_word, 64'h0);
        end else begin
          want = packet_words_due.pop_front();
          if (got_word !== want.word) flag_mismatch("out_word", got_word, want.word);
          if (got_last !== want.last) flag_mismatch("out_last_word", 64'(got_last),
                                                    64'(want.last));
        end
      end
      if (hold_on) begin
        nxt = 1'b1;
      end else if (calm_rx > 0) begin
        calm_rx--;
        nxt = 1'b0;
      end else if ($urandom_range(0, 49) == 0) begin
        calm_rx = CALM_CYCLES;
        nxt = 1'b0;
      end else begin
        nxt = ($urandom_range(0, 99) < rx_stall_pct);
      end
      out_stall <= nxt;
    end
  end

  // run limit
  initial begin
    cycle_count = 0;
    while (cycle_count <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // stimulus
  initial begin
    int        tx_pcts [NUM_PHASES];
    int        rx_pcts [NUM_PHASES];
    int        items_mark;
    int        pick;
    byte_run_t rnd_run;
    tx_pcts = '{0, 80, 0, 36};
    rx_pcts = '{0, 0, 80, 36};
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_data_byte   <= 8'h00;
    in_frame_start <= 1'b0;
    in_frame_end   <= 1'b0;
    in_format_code <= FMT_UNKNOWN;
    seg_fill       = 0;
    seg_bytes      = 0;
    seg_id         = 8'd0;
    seg_type       = fps_pkg::TYPE_NONE;
    seg_active     = 1'b0;
    bad_count      = 0;
    bytes_taken    = 0;
    tx_idle_pct    = 0;
    rx_stall_pct   = 0;
    calm_tx        = 0;
    calm_rx        = 0;
    hold_req       = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed runs; the output is held off while the payload fills
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (r == HOLD_ROW) hold_req = 1'b1;
      send_run(table_runs[r]);
    end
    in_valid <= 1'b0;
    drain_words();

    // random frames, one idle and stall mix per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      tx_idle_pct  = tx_pcts[ph];
      rx_stall_pct = rx_pcts[ph];
      items_mark   = bytes_taken;
      while (bytes_taken - items_mark < PHASE_BYTES) begin
        pick    = $urandom_range(0, 99);
        rnd_run = '0;
        rnd_run.mode = DATA_RAND;
        rnd_run.fmt  = 2'($urandom_range(0, 3));
        if (pick < 15) begin
          // stray bytes with no start flag
          rnd_run.count = $urandom_range(1, 3);
        end else begin
          rnd_run.start_first = 1'b1;
          rnd_run.end_last    = ($urandom_range(0, 99) < 85);
          rnd_run.count       = $urandom_range(1, 12);
        end
        send_run(rnd_run);
      end
      // sender pauses until every packet word is out
      in_valid <= 1'b0;
      drain_words();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/fps_pkg.sv
hdl/fps_dpath.sv
hdl/fps_ctrl.sv
hdl/frame_packet_segmenter.sv
bench/testbench.sv
